// ===== sv/gss_pkg.sv =====
package gss_pkg;

	localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
	localparam logic [16:0] ONE_Q16 = 17'h1_0000;
	localparam logic [15:0] ITER_MAX = 16'hFFFF;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_PAIR  = 1'b1;

	localparam logic [1:0] OUTCOME_CONVERGED = 2'd0;
	localparam logic [1:0] OUTCOME_LIMIT     = 2'd1;
	localparam logic [1:0] OUTCOME_RUNNING   = 2'd2;

	localparam logic [1:0] CFG_GOLDEN_FRACTION    = 2'd0;
	localparam logic [1:0] CFG_TOLERANCE_FRACTION = 2'd1;
	localparam logic [1:0] CFG_ITERATION_LIMIT    = 2'd2;

	localparam logic [15:0] GOLDEN_RESET    = 16'd40503;
	localparam logic [31:0] TOLERANCE_RESET = 32'd2147;
	localparam logic [15:0] LIMIT_RESET     = 16'd0;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] value_at_first;
		logic signed [31:0] value_at_second;
	} gss_in_t;

	typedef struct packed {
		logic [1:0]         outcome;
		logic               is_final;
		logic [31:0]        first_point;
		logic [31:0]        second_point;
		logic [31:0]        best_point;
		logic signed [31:0] best_value;
		logic [15:0]        iteration_count;
	} gss_out_t;

endpackage

// ===== sv/golden_section_search_step.sv =====
// Golden-section line search controller working in the segment coordinate
// t, unsigned Q1.31 with 0x80000000 standing for 1.0.
// Input items arrive on in_valid/in_stall/in_item. A start item resets the
// bracket to 0..1.0 and returns both probe points; a pair item carries the
// objective values at the current probes and returns the next probes, or a
// stop notice, or (after a stop) the final best point and value. A pair item
// while no search is active is consumed and gives no result.
// Results leave on out_valid/out_stall/out_item, one per producing item.
// out_valid comes from a result register behind an input register, so an
// accepted item passes the input register and then the result register.
// One item is taken every cycle while in_stall is low; the bracket update
// (one 32x17 multiply with its subtract and add, then the width compare)
// is combinational and sits between those two registers.
// When out_stall holds a waiting result, the input register keeps one more
// item and in_stall rises; nothing is dropped.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are expected only while the block is idle.
// Reset clears the pipeline, returns to idle with the bracket at 0..1.0 and
// loads the register defaults.
module golden_section_search_step
	import gss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  gss_in_t     in_item,

	output logic        out_valid,
	input  logic        out_stall,
	output gss_out_t    out_item,

	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_RUN,
		PH_STOPPED
	} phase_t;

	phase_t      phase_q;
	logic [15:0] golden_q;
	logic [31:0] tolerance_q;
	logic [15:0] limit_q;

	logic [31:0] bracket_low_q;
	logic [31:0] bracket_high_q;
	logic [31:0] probe_first_q;
	logic [31:0] probe_second_q;
	logic [15:0] iters_q;
	logic        stop_cause_q;

	logic        valid_s1;
	gss_in_t     item_s1;

	logic        out_valid_q;
	gss_out_t    out_item_q;

	// Rounded interpolation lo + round(frac * (hi - lo)); the bracket may be inverted.
	function automatic logic [31:0] interp(input logic [31:0] lo, input logic [31:0] hi,
			input logic [16:0] frac);
		logic        neg;
		logic [31:0] mag;
		logic [48:0] prod;
		logic [48:0] shifted;
		begin
			neg = hi < lo;
			mag = neg ? (lo - hi) : (hi - lo);
			prod = {17'b0, mag} * {32'b0, frac};
			shifted = (prod + 49'h8000) >> 16;
			return neg ? (lo - shifted[31:0]) : (lo + shifted[31:0]);
		end
	endfunction

	logic        out_free;
	logic        consume;
	logic        produces;
	logic        first_lower;
	logic [16:0] comp;
	logic [15:0] iters_inc;
	logic        limit_hit;
	logic [31:0] ip_lo;
	logic [31:0] ip_hi;
	logic [16:0] ip_frac;
	logic [31:0] ip_res;
	logic [31:0] new_low;
	logic [31:0] new_high;
	logic [31:0] new_first;
	logic [31:0] new_second;
	logic [31:0] new_width;
	logic        converged;

	assign out_free = !out_valid_q || !out_stall;
	assign consume  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	// A pair item while idle is consumed without a result.
	assign produces = consume && ((item_s1.kind == KIND_START) || (phase_q != PH_IDLE));

	assign first_lower = $signed(item_s1.value_at_first) < $signed(item_s1.value_at_second);
	assign comp        = ONE_Q16 - {1'b0, golden_q};
	assign iters_inc   = (iters_q != ITER_MAX) ? iters_q + 16'd1 : iters_q;
	assign limit_hit   = (limit_q != 16'd0) && (iters_inc >= limit_q);

	// A smaller first value drops the upper end, otherwise the lower end moves up.
	assign ip_lo   = first_lower ? bracket_low_q : probe_first_q;
	assign ip_hi   = first_lower ? probe_second_q : bracket_high_q;
	assign ip_frac = first_lower ? comp : {1'b0, golden_q};
	assign ip_res  = interp(ip_lo, ip_hi, ip_frac);

	assign new_low    = ip_lo;
	assign new_high   = ip_hi;
	assign new_first  = first_lower ? ip_res : probe_second_q;
	assign new_second = first_lower ? probe_first_q : ip_res;
	assign new_width  = (new_high >= new_low) ? (new_high - new_low) : (new_low - new_high);
	assign converged  = new_width < tolerance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			golden_q       <= GOLDEN_RESET;
			tolerance_q    <= TOLERANCE_RESET;
			limit_q        <= LIMIT_RESET;
			bracket_low_q  <= '0;
			bracket_high_q <= ONE_Q31;
			probe_first_q  <= '0;
			probe_second_q <= '0;
			iters_q        <= '0;
			stop_cause_q   <= 1'b0;
			valid_s1       <= 1'b0;
			item_s1        <= '0;
			out_valid_q    <= 1'b0;
			out_item_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_GOLDEN_FRACTION:    golden_q    <= cfg_data[15:0];
					CFG_TOLERANCE_FRACTION: tolerance_q <= cfg_data;
					CFG_ITERATION_LIMIT:    limit_q     <= cfg_data[15:0];
					default: ;
				endcase
			end

			if (!in_stall) begin
				valid_s1 <= in_valid;
				if (in_valid) begin
					item_s1 <= in_item;
				end
			end

			if (out_free) begin
				out_valid_q <= produces;
			end

			if (consume) begin
				if (item_s1.kind == KIND_START) begin
					bracket_low_q              <= '0;
					bracket_high_q             <= ONE_Q31;
					probe_first_q              <= {comp, 15'b0};
					probe_second_q             <= {1'b0, golden_q, 15'b0};
					iters_q                    <= '0;
					stop_cause_q               <= 1'b0;
					phase_q                    <= PH_RUN;
					out_item_q.outcome         <= OUTCOME_RUNNING;
					out_item_q.is_final        <= 1'b0;
					out_item_q.first_point     <= {comp, 15'b0};
					out_item_q.second_point    <= {1'b0, golden_q, 15'b0};
					out_item_q.best_point      <= '0;
					out_item_q.best_value      <= '0;
					out_item_q.iteration_count <= '0;
				end else begin
					unique case (phase_q)
						PH_STOPPED: begin
							phase_q                    <= PH_IDLE;
							out_item_q.outcome         <= {1'b0, stop_cause_q};
							out_item_q.is_final        <= 1'b1;
							out_item_q.first_point     <= probe_first_q;
							out_item_q.second_point    <= probe_second_q;
							out_item_q.best_point      <= first_lower ? probe_first_q
									: probe_second_q;
							out_item_q.best_value      <= first_lower
									? item_s1.value_at_first : item_s1.value_at_second;
							out_item_q.iteration_count <= iters_q;
						end
						PH_RUN: begin
							iters_q                    <= iters_inc;
							out_item_q.is_final        <= 1'b0;
							out_item_q.best_point      <= '0;
							out_item_q.best_value      <= '0;
							out_item_q.iteration_count <= iters_inc;
							if (limit_hit) begin
								stop_cause_q            <= 1'b1;
								phase_q                 <= PH_STOPPED;
								out_item_q.outcome      <= OUTCOME_LIMIT;
								out_item_q.first_point  <= probe_first_q;
								out_item_q.second_point <= probe_second_q;
							end else begin
								bracket_low_q           <= new_low;
								bracket_high_q          <= new_high;
								probe_first_q           <= new_first;
								probe_second_q          <= new_second;
								out_item_q.first_point  <= new_first;
								out_item_q.second_point <= new_second;
								if (converged) begin
									stop_cause_q       <= 1'b0;
									phase_q            <= PH_STOPPED;
									out_item_q.outcome <= OUTCOME_CONVERGED;
								end else begin
									out_item_q.outcome <= OUTCOME_RUNNING;
								end
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Probes are convex combinations of the bracket ends.
	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_item_q.first_point <= ONE_Q31)
			&& (out_item_q.second_point <= ONE_Q31))
		else $error("probe point outside the segment");

	// A final item only ever reports a stop cause.
	a_final_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_item_q.is_final) |-> (out_item_q.outcome != OUTCOME_RUNNING))
		else $error("final item reports a running search");

	// A consumed start item always produces a fresh running result.
	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && item_s1.kind == KIND_START) |=> (out_valid_q
			&& out_item_q.outcome == OUTCOME_RUNNING && out_item_q.iteration_count == 16'd0
			&& !out_item_q.is_final))
		else $error("start item did not produce a running result");

	// The input side only stalls while an item is held in the input register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked item");

endmodule
